// ===== src/signed_restoring_divider_top_macros.svh =====
`ifndef SIGNED_RESTORING_DIVIDER_TOP_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_TOP_MACROS_SVH

// concurrent check, off while reset is asserted
`define SDIV_CHECK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check that also holds across reset
`define SDIV_CHECK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sdiv_pkg.sv =====
package sdiv_pkg;

    localparam int unsigned WIDTH = 32;

    typedef struct packed {
        logic signed [WIDTH-1:0] dividend;
        logic signed [WIDTH-1:0] divisor;
    } sdiv_in_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] quotient;
        logic                    divide_by_zero;
    } sdiv_out_t;

    // partial state carried down the cell row
    typedef struct packed {
        logic [WIDTH-1:0] rem;    // partial remainder
        logic [WIDTH-1:0] nq;     // dividend bits out at the top, quotient bits in at the bottom
        logic [WIDTH-1:0] d;      // divisor magnitude
        logic             neg;    // quotient gets negated
        logic             dbz;    // divisor was zero
    } sdiv_work_t;

endpackage

// ===== src/sdiv_prep.sv =====
module sdiv_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdiv_pkg::sdiv_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdiv_pkg::sdiv_work_t out_work
);
    import sdiv_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    sdiv_work_t       work_reg;
    sdiv_work_t       work_next;
    logic             load;
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    assign x = $unsigned(in_data.dividend);
    assign y = $unsigned(in_data.divisor);

    always_comb begin
        work_next.rem = '0;
        // most negative value negates to itself, read as 2^(WIDTH-1) unsigned
        work_next.nq  = x[WIDTH-1] ? (~x + 1'b1) : x;
        work_next.d   = y[WIDTH-1] ? (~y + 1'b1) : y;
        work_next.neg = x[WIDTH-1] ^ y[WIDTH-1];
        work_next.dbz = (y == '0);
        valid_next    = load ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== src/sdiv_cell.sv =====
module sdiv_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdiv_pkg::sdiv_work_t in_work,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdiv_pkg::sdiv_work_t out_work
);
    import sdiv_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    sdiv_work_t       work_reg;
    sdiv_work_t       work_next;
    logic             load;
    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH-1:0] diff;
    logic             carry;
    logic             qbit;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign carry  = in_work.rem[WIDTH-1];
    assign rem_sh = {in_work.rem[WIDTH-2:0], in_work.nq[WIDTH-1]};
    assign diff   = rem_sh - in_work.d;
    assign qbit   = carry || (rem_sh >= in_work.d);

    always_comb begin
        work_next     = in_work;
        work_next.rem = qbit ? diff : rem_sh;
        work_next.nq  = {in_work.nq[WIDTH-2:0], qbit};
        valid_next    = load ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== src/sdiv_fix.sv =====
module sdiv_fix (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdiv_pkg::sdiv_work_t in_work,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sdiv_pkg::sdiv_out_t  m_data
);
    import sdiv_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sdiv_out_t data_reg;
    sdiv_out_t data_next;
    logic      load;

    assign load     = !valid_reg || m_ready;
    assign in_ready = load;

    always_comb begin
        priority if (in_work.dbz) begin
            data_next.quotient = '0;
        end else if (in_work.neg) begin
            data_next.quotient = $signed(~in_work.nq + 1'b1);
        end else begin
            data_next.quotient = $signed(in_work.nq);
        end
        data_next.divide_by_zero = in_work.dbz;
        valid_next               = load ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== src/signed_restoring_divider_top.sv =====
// structure: WIDTH + 2 register stages: one register for the operand magnitudes,
//   one cell per quotient bit, one output register
// throughput: one division per cycle while the result side keeps up
// reset: aresetn synchronous, active low, empties every stage; data registers are not reset
module signed_restoring_divider_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdiv_pkg::sdiv_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sdiv_pkg::sdiv_out_t m_data
);
    import sdiv_pkg::*;

    // link k feeds cell k; link WIDTH feeds the output stage
    logic       link_valid [WIDTH+1];
    logic       link_ready [WIDTH+1];
    sdiv_work_t link_work  [WIDTH+1];

    // front: sign split, magnitudes, zero divisor detect
    sdiv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_work  (link_work[0])
    );

    // row of restoring cells, msb of the quotient first; each stage moves
    // whenever it is empty or its neighbor takes its item, so bubbles close up
    for (genvar k = 0; k < WIDTH; k++) begin : g_cell
        sdiv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_work   (link_work[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_work  (link_work[k+1])
        );
    end

    // back: sign fix, zero divisor forces quotient 0, result register
    sdiv_fix u_fix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (link_valid[WIDTH]),
        .in_ready (link_ready[WIDTH]),
        .in_work  (link_work[WIDTH]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== src/sdiv_checker.sv =====
`include "signed_restoring_divider_top_macros.svh"

module sdiv_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sdiv_pkg::sdiv_out_t m_data
);
    import sdiv_pkg::*;

    `SDIV_CHECK_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    `SDIV_CHECK(a_hold_result, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    `SDIV_CHECK(a_zero_quotient, aclk, aresetn, m_valid && m_data.divide_by_zero |-> m_data.quotient == '0, "divide by zero with nonzero quotient")

    `SDIV_CHECK(a_full_only_on_stall, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "input stalled while result side free")

    `SDIV_CHECK(a_accept_into_empty, aclk, aresetn, !s_valid && s_ready |=> s_ready, "ready dropped without a new item")

endmodule

bind signed_restoring_divider_top sdiv_checker u_sdiv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_signed_restoring_divider_top.sv =====
`timescale 1ns / 100ps

module tb_signed_restoring_divider_top;

    import sdiv_pkg::*;

    // drain time after the last result, longer than the block's pipeline
    localparam int DRAIN_CYCLES   = WIDTH + 8;
    // longest stretch with no accepted item on either side before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    // receiver hold-off used to fill the pipeline and back up the input
    localparam int HOLD_CYCLES    = 200;
    localparam int IDLE_PERCENT   = 27;

    localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic signed [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sdiv_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sdiv_out_t m_data;

    // expected quotients, oldest first
    sdiv_out_t pending_quotients[$];
    int        mismatch_count = 0;

    // knobs set by the test tasks, read by the sender task and the receiver process
    bit tx_idle_en  = 1'b1;    // sender inserts random gaps
    bit rx_no_idle  = 1'b0;    // receiver keeps ready high
    int rx_hold_req = 0;       // nonzero asks the receiver for a hold-off

    signed_restoring_divider_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // ------------------------------------------------------------------
    // predictor: signed quotient truncated toward zero
    // ------------------------------------------------------------------
    function automatic sdiv_out_t predict_quotient(sdiv_in_t op);
        logic [WIDTH-1:0] n_bits;
        logic [WIDTH-1:0] d_bits;
        logic [WIDTH-1:0] mag_n;
        logic [WIDTH-1:0] mag_d;
        logic [WIDTH-1:0] mag_q;
        sdiv_out_t        res;
        n_bits = op.dividend;
        d_bits = op.divisor;
        res    = '0;
        if (d_bits == '0) begin
            // zero divisor: flag it, quotient forced to zero
            res.quotient       = '0;
            res.divide_by_zero = 1'b1;
        end else begin
            // two's complement magnitude; the most negative value maps to 2^(WIDTH-1)
            mag_n = n_bits[WIDTH-1] ? (~n_bits + 1'b1) : n_bits;
            mag_d = d_bits[WIDTH-1] ? (~d_bits + 1'b1) : d_bits;
            mag_q = mag_n / mag_d;
            // negate when signs differ; most negative by -1 wraps back onto itself
            if (n_bits[WIDTH-1] != d_bits[WIDTH-1])
                mag_q = ~mag_q + 1'b1;
            res.quotient       = mag_q;
            res.divide_by_zero = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random operands, biased toward the interesting corners
    // ------------------------------------------------------------------
    function automatic logic signed [WIDTH-1:0] rand_operand();
        logic signed [WIDTH-1:0] v;
        case ($urandom_range(7))
            0, 1: v = $urandom;
            2: v = $signed($urandom_range(40)) - 20;
            3: v = MOST_NEG + $signed($urandom_range(3));
            4: v = MOST_POS - $signed($urandom_range(3));
            5: begin
                // power of two, either sign
                v = 1 <<< $urandom_range(WIDTH - 1);
                if ($urandom_range(1)) v = -v;
            end
            6: v = $signed(16'($urandom));
            default: v = $signed(8'($urandom));
        endcase
        return v;
    endfunction

    function automatic logic signed [WIDTH-1:0] rand_divisor();
        logic signed [WIDTH-1:0] v;
        case ($urandom_range(24))
            0: v = '0;
            1: v = 1;
            2: v = -1;
            default: v = rand_operand();
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // sender: one item per call, called and returning at a falling edge
    // ------------------------------------------------------------------
    task automatic send_division(input logic signed [WIDTH-1:0] dividend,
                                 input logic signed [WIDTH-1:0] divisor);
        int gap;
        if (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_data.dividend <= dividend;
        s_data.divisor  <= divisor;
        // hold the item until the handshake
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // input side monitor: every accepted item gets its expected quotient queued
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_quotients.push_back(predict_quotient(s_data));
    end

    // ------------------------------------------------------------------
    // receiver: random ready, a no-idle mode and a counted hold-off
    // ------------------------------------------------------------------
    int rx_hold_left = 0;

    always @(negedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (!aresetn)
            m_ready <= 1'b0;
        else if (rx_hold_left != 0) begin
            // long stall on the result side, pipeline fills up behind it
            m_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_no_idle)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input sdiv_out_t want,
                                   input sdiv_out_t got);
        mismatch_count++;
        $display("mismatch at %0t: %s: expected quotient %0d dbz %0b, got quotient %0d dbz %0b",
                 $realtime, what, want.quotient, want.divide_by_zero,
                 got.quotient, got.divide_by_zero);
    endtask

    always @(posedge aclk) begin
        sdiv_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_quotients.size() == 0) begin
                report_mismatch("result with no item outstanding", '0, m_data);
            end else begin
                want = pending_quotients.pop_front();
                if (m_data.quotient !== want.quotient)
                    report_mismatch("quotient", want, m_data);
                if (m_data.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", want, m_data);
            end
        end
    end

    // watchdog: cycles with no accepted item on either side
    int stuck_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL signed_restoring_divider_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corners of both fields, all sign combinations, zero divisor
    task automatic test_directed_corners();
        tx_idle_en = 1'b1;
        rx_no_idle = 1'b0;
        send_division(0, 1);
        send_division(1, 1);
        send_division(-1, 1);
        send_division(7, 2);
        send_division(-7, 2);
        send_division(7, -2);
        send_division(-7, -2);
        send_division(MOST_POS, 1);
        send_division(MOST_NEG, 1);
        // most negative by minus one wraps
        send_division(MOST_NEG, -1);
        send_division(MOST_NEG, MOST_NEG);
        send_division(MOST_POS, MOST_POS);
        send_division(MOST_POS, MOST_NEG);
        send_division(MOST_NEG, MOST_POS);
        send_division(MOST_NEG, 2);
        send_division(1, MOST_POS);
        send_division(-1, MOST_NEG);
        send_division(123456789, -1000);
        // zero divisor with assorted dividends, then one division by minus one
        send_division(0, 0);
        send_division(MOST_NEG, 0);
        send_division(MOST_POS, 0);
        send_division(-1, 0);
        send_division(5, -1);
    endtask

    // random operands, both sides idling at random
    task automatic test_random_idling(input int count);
        logic signed [WIDTH-1:0] n;
        tx_idle_en = 1'b1;
        rx_no_idle = 1'b0;
        repeat (count) begin
            n = ($urandom_range(49) == 0) ? MOST_NEG : rand_operand();
            send_division(n, rand_divisor());
        end
    endtask

    // long stretch at full rate, no gaps on either side
    task automatic test_back_to_back(input int count);
        tx_idle_en = 1'b0;
        rx_no_idle = 1'b1;
        repeat (count) send_division(rand_operand(), rand_divisor());
    endtask

    // receiver stalls for a long while, sender keeps offering until the input backs up
    task automatic test_output_hold(input int count);
        tx_idle_en  = 1'b0;
        rx_no_idle  = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        repeat (count) send_division(rand_operand(), rand_divisor());
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        // synchronous reset held low from time zero, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_corners();
        test_random_idling(300);
        test_back_to_back(120);
        test_output_hold(90);
        test_random_idling(170);

        s_valid <= 1'b0;
        tx_idle_en = 1'b1;
        rx_no_idle = 1'b0;

        // drain everything outstanding, then wait DRAIN_CYCLES more for strays
        while (pending_quotients.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_quotients.size() == 0)
            $display("PASS signed_restoring_divider_top");
        else
            $display("FAIL signed_restoring_divider_top");
        $finish;
    end

endmodule
